### hw/rtl/odd_even_transposition_sort_top_macros.svh
// Assertion macros shared by the sorter RTL.
// Define NO_ASSERTIONS to compile them out; no other dependencies.
`ifndef ODD_EVEN_TRANSPOSITION_SORT_TOP_MACROS_SVH
`define ODD_EVEN_TRANSPOSITION_SORT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge out of reset
`define OETS_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Same-cycle implication
`define OETS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define OETS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define OETS_ASSERT_ALWAYS(label, cond, msg)
`define OETS_ASSERT_IMPL(label, ante, cons, msg)
`define OETS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### hw/rtl/oets_pkg.sv
// Shared constants and types of the odd-even transposition sorter.
// No dependencies; used by oets_cell, oets_ctrl and the top level.
package oets_pkg;

	localparam int MAX_ELEMENTS = 64;
	localparam int IDX_W        = $clog2(MAX_ELEMENTS);
	localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
	localparam int DATA_W       = 32;

	// What every cell does in the current cycle
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_LOAD = 2'd1,
		CELL_SORT = 2'd2,
		CELL_EMIT = 2'd3
	} cell_op_t;

	// Broadcast control from the sequencer to the cell row
	typedef struct packed {
		cell_op_t          op;
		logic              phase;  // 1: pairs (1,2),(3,4)..  0: pairs (0,1),(2,3)..
		logic [CNT_W-1:0]  count;  // values in the current set
	} cell_ctrl_t;

endpackage

### hw/rtl/odd_even_transposition_sort_top.sv
// Odd-even transposition sorter for sets of 1 to 64 signed 32-bit values.
// Values enter one beat per cycle, then the 64-cell row runs alternating
// odd-pair and even-pair exchange phases, one phase per cycle, until an
// odd+even round makes no swap. The sorted set leaves one beat per cycle
// while m_tready is high, smallest first, with tlast on the final value.
// The input is not ready from the last load beat until the last output
// beat is taken. Set size comes from element_count (address 0); zero
// means one, values above 64 mean 64. Depends on oets_pkg, oets_ctrl
// and oets_cell.
module odd_even_transposition_sort_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] sorted_value
	output logic        m_tlast
);
	import oets_pkg::*;

	cell_ctrl_t                          cell_ctrl;
	logic [MAX_ELEMENTS-1:0]             swap;
	logic [MAX_ELEMENTS-1:0][DATA_W-1:0] value;
	logic                                any_swap;

	assign any_swap = |swap;
	assign m_tdata  = value[0];

	// Sequencer and register port
	oets_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tlast   (m_tlast),
		.any_swap  (any_swap),
		.cell_ctrl (cell_ctrl)
	);

	// Row of cells; input enters at cell 0, output leaves from cell 0
	for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
		logic [DATA_W-1:0] left_value;
		logic [DATA_W-1:0] right_value;
		logic              left_swap;

		if (i == 0) begin : g_first
			assign left_value = s_tdata;
			assign left_swap  = 1'b0;
		end else begin : g_mid
			assign left_value = value[i-1];
			assign left_swap  = swap[i-1];
		end

		if (i == MAX_ELEMENTS - 1) begin : g_last
			assign right_value = value[i];
		end else begin : g_inner
			assign right_value = value[i+1];
		end

		oets_cell u_cell (
			.clk         (clk),
			.cell_index  (IDX_W'(i)),
			.ctrl        (cell_ctrl),
			.left_value  (left_value),
			.right_value (right_value),
			.left_swap   (left_swap),
			.swap        (swap[i]),
			.value       (value[i])
		);
	end

endmodule

### hw/rtl/oets_cell.sv
// One storage cell of the sorter row: holds a value, shifts on load/emit,
// compare-exchanges with a neighbor during sort. Depends on oets_pkg.
module oets_cell (
	input  logic                          clk,
	input  logic [oets_pkg::IDX_W-1:0]    cell_index,
	input  oets_pkg::cell_ctrl_t          ctrl,
	input  logic [oets_pkg::DATA_W-1:0]   left_value,
	input  logic [oets_pkg::DATA_W-1:0]   right_value,
	input  logic                          left_swap,
	output logic                          swap,
	output logic [oets_pkg::DATA_W-1:0]   value
);
	import oets_pkg::*;

	logic [DATA_W-1:0] value_q;
	logic              is_left;

	// This cell is the lower member of an active pair
	assign is_left = (cell_index[0] == ctrl.phase) &&
		(({1'b0, cell_index} + CNT_W'(1)) < ctrl.count);

	assign swap  = (ctrl.op == CELL_SORT) && is_left &&
		($signed(value_q) > $signed(right_value));
	assign value = value_q;

	// Value register
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_LOAD: value_q <= left_value;
			CELL_EMIT: value_q <= right_value;
			CELL_SORT: begin
				if (swap) begin
					value_q <= right_value;
				end else if (left_swap) begin
					value_q <= left_value;
				end
			end
			default: value_q <= value_q;
		endcase
	end

endmodule

### hw/rtl/oets_ctrl.sv
// Sequencer of the sorter: count register on the APB port, load / sort /
// emit state machine and stream handshakes. Depends on oets_pkg and macros.
`include "odd_even_transposition_sort_top_macros.svh"

module oets_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic                  m_tlast,
	input  logic                  any_swap,
	output oets_pkg::cell_ctrl_t  cell_ctrl
);
	import oets_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SORT,
		ST_EMIT
	} state_t;

	localparam logic [6:0] COUNT_RESET = 7'd64;

	state_t           state_q;
	logic [6:0]       element_count_q;
	logic [CNT_W-1:0] load_q;
	logic [CNT_W-1:0] rem_q;
	logic             phase_q;
	logic             round_swap_q;
	logic [CNT_W-1:0] count;
	logic             cfg_write;
	logic             s_beat;
	logic             m_beat;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign prdata    = (paddr[2] == 1'b0) ? {25'd0, element_count_q} : 32'd0;

	// Effective set size: zero means one, saturate at capacity
	always_comb begin
		if (element_count_q == 7'd0) begin
			count = CNT_W'(1);
		end else if ({{(32-7){1'b0}}, element_count_q} > 32'(MAX_ELEMENTS)) begin
			count = CNT_W'(MAX_ELEMENTS);
		end else begin
			count = CNT_W'(element_count_q);
		end
	end

	assign s_tready = (state_q == ST_LOAD);
	assign m_tvalid = (state_q == ST_EMIT);
	assign m_tlast  = (rem_q == CNT_W'(1));
	assign s_beat   = s_tvalid && s_tready;
	assign m_beat   = m_tvalid && m_tready;

	// Cell row control
	always_comb begin
		cell_ctrl.phase = phase_q;
		cell_ctrl.count = count;
		if (s_beat) begin
			cell_ctrl.op = CELL_LOAD;
		end else if (state_q == ST_SORT) begin
			cell_ctrl.op = CELL_SORT;
		end else if (m_beat) begin
			cell_ctrl.op = CELL_EMIT;
		end else begin
			cell_ctrl.op = CELL_HOLD;
		end
	end

	// State and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_LOAD;
			element_count_q <= COUNT_RESET;
			load_q          <= '0;
			rem_q           <= '0;
			phase_q         <= 1'b1;
			round_swap_q    <= 1'b0;
		end else begin
			if (cfg_write && paddr[2] == 1'b0) begin
				element_count_q <= pwdata[6:0];
				load_q          <= '0;
			end
			case (state_q)
				ST_LOAD: begin
					if (s_beat) begin
						if (load_q + CNT_W'(1) == count) begin
							load_q       <= '0;
							rem_q        <= count;
							phase_q      <= 1'b1;
							round_swap_q <= 1'b0;
							state_q      <= ST_SORT;
						end else begin
							load_q <= load_q + CNT_W'(1);
						end
					end
				end
				ST_SORT: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						round_swap_q <= any_swap;
					end else if (!(round_swap_q || any_swap)) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (m_beat) begin
						rem_q <= rem_q - CNT_W'(1);
						if (m_tlast) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	`OETS_ASSERT_ALWAYS(a_no_overlap, !(s_tready && m_tvalid), "load and emit overlap")
	`OETS_ASSERT_IMPL(a_load_bound, state_q == ST_LOAD, load_q < count, "load count overran set")
	`OETS_ASSERT_IMPL(a_emit_rem, state_q == ST_EMIT, rem_q != '0 && rem_q <= count,
		"emit count out of range")
	`OETS_ASSERT_NEXT(a_last_to_load, m_beat && m_tlast, s_tready && load_q == '0,
		"no return to load after last beat")
	`OETS_ASSERT_IMPL(a_swap_only_sort, any_swap, state_q == ST_SORT, "exchange outside sort")

endmodule

### dv/tb.sv
// Self-checking testbench for odd_even_transposition_sort_top: loads sets of signed values,
// predicts the ascending output with its own transposition sort, checks every output beat.
// Depends on oets_pkg and the sorter RTL only.
module tb;
	import oets_pkg::*;

	localparam int HALF_PERIOD     = 10;
	localparam int RESET_CYCLES    = 8;
	localparam int SETTLE_CYCLES   = 8;
	localparam int TAIL_CYCLES     = 64;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int DIR_ROWS        = 36;

	// Register map
	localparam logic [2:0] ADDR_ELEMENT_COUNT = 3'd0;
	localparam logic [2:0] ADDR_SPARE         = 3'd4;

	typedef enum logic [1:0] {
		ROW_WRITE = 2'd0,
		ROW_READ  = 2'd1,
		ROW_BEAT  = 2'd2
	} row_kind_t;

	// One directed step; want_* is filled in only where typed is set
	typedef struct packed {
		row_kind_t   kind;
		logic [2:0]  addr;
		logic [31:0] data;
		logic        typed;
		logic [31:0] want_data;
		logic        want_last;
	} stim_row_t;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} sorted_beat_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] value
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] sorted_value
	logic        m_tlast;

	// Sorter model state
	logic [31:0]  value_mem [MAX_ELEMENTS];
	logic [6:0]   count_reg;
	int unsigned  loaded;
	sorted_beat_t sorted_q [$];

	int src_idle_pct;
	int sink_stall_pct;
	int errors;
	int beats_in;
	int beats_out;
	int sets_out;
	int cycles;
	sorted_beat_t want_beat;

	stim_row_t directed_rows [DIR_ROWS] = '{
		'{ROW_READ,  ADDR_ELEMENT_COUNT, 32'd0,        1'b1, 32'd64,       1'b0},
		// single-value sets echo the input
		'{ROW_WRITE, ADDR_ELEMENT_COUNT, 32'd1,        1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h8000_0000, 1'b1, 32'h8000_0000, 1'b1},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h7fff_ffff, 1'b1, 32'h7fff_ffff, 1'b1},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'hffff_ffff, 1'b1, 32'hffff_ffff, 1'b1},
		// count of zero acts as one
		'{ROW_WRITE, ADDR_ELEMENT_COUNT, 32'd0,        1'b0, 32'd0,        1'b0},
		'{ROW_READ,  ADDR_ELEMENT_COUNT, 32'd0,        1'b1, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b1},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'hdead_beef, 1'b1, 32'hdead_beef, 1'b1},
		// reversed extremes
		'{ROW_WRITE, ADDR_ELEMENT_COUNT, 32'd2,        1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h7fff_ffff, 1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h8000_0000, 1'b0, 32'd0,        1'b0},
		// descending across the sign boundary, odd size
		'{ROW_WRITE, ADDR_ELEMENT_COUNT, 32'd5,        1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h7fff_ffff, 1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h0000_0001, 1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h0000_0000, 1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'hffff_ffff, 1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h8000_0000, 1'b0, 32'd0,        1'b0},
		// partial set dropped by a count write
		'{ROW_WRITE, ADDR_ELEMENT_COUNT, 32'd4,        1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'd9,        1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'd8,        1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'd7,        1'b0, 32'd0,        1'b0},
		'{ROW_WRITE, ADDR_ELEMENT_COUNT, 32'd3,        1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'hffff_ffff, 1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'h0000_0000, 1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'hffff_ffff, 1'b0, 32'd0,        1'b0},
		// write to an unmapped address leaves the count alone
		'{ROW_WRITE, ADDR_SPARE,         32'd1,        1'b0, 32'd0,        1'b0},
		'{ROW_READ,  ADDR_ELEMENT_COUNT, 32'd0,        1'b1, 32'd3,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'd2,        1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'd1,        1'b0, 32'd0,        1'b0},
		'{ROW_BEAT,  ADDR_ELEMENT_COUNT, 32'd2,        1'b0, 32'd0,        1'b0},
		// upper write bits dropped; counts above capacity
		'{ROW_WRITE, ADDR_ELEMENT_COUNT, 32'hffff_ff87, 1'b0, 32'd0,        1'b0},
		'{ROW_READ,  ADDR_ELEMENT_COUNT, 32'd0,        1'b1, 32'd7,        1'b0},
		'{ROW_WRITE, ADDR_ELEMENT_COUNT, 32'd100,      1'b0, 32'd0,        1'b0},
		'{ROW_READ,  ADDR_ELEMENT_COUNT, 32'd0,        1'b1, 32'd100,      1'b0}
	};

	odd_even_transposition_sort_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// Values per set after zero and saturation rules
	function automatic int unsigned set_size();
		int unsigned n;
		n = count_reg;
		if (n == 0)
			n = 1;
		if (n > MAX_ELEMENTS)
			n = MAX_ELEMENTS;
		return n;
	endfunction

	// One compare-exchange phase over pairs (first,first+1),...; reports any swap
	function automatic bit exchange_pairs(int unsigned first, int unsigned n);
		bit          swapped;
		logic [31:0] held;
		int unsigned i;
		swapped = 1'b0;
		for (i = first; i + 1 < n; i += 2) begin
			if ($signed(value_mem[i]) > $signed(value_mem[i + 1])) begin
				held             = value_mem[i];
				value_mem[i]     = value_mem[i + 1];
				value_mem[i + 1] = held;
				swapped          = 1'b1;
			end
		end
		return swapped;
	endfunction

	// Store one value; when the set fills, sort it and queue the sorted beats
	task automatic load_value(input logic [31:0] v, input bit queue_results);
		int unsigned  n;
		int unsigned  k;
		bit           odd_sw;
		bit           even_sw;
		sorted_beat_t b;
		n = set_size();
		if (loaded >= n)
			loaded = 0;
		value_mem[loaded] = v;
		loaded++;
		if (loaded < n)
			return;
		do begin
			odd_sw  = exchange_pairs(1, n);
			even_sw = exchange_pairs(0, n);
		end while (odd_sw || even_sw);
		for (k = 0; k < n; k++) begin
			b.value = value_mem[k];
			b.last  = (k + 1 == n);
			if (queue_results)
				sorted_q.push_back(b);
		end
		loaded = 0;
	endtask

	// Source side: optional idle cycles, then hold the beat until taken
	task automatic send_beat(input logic [31:0] v, input bit queue_results);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		do
			@(posedge clk);
		while (!s_tready);
		beats_in++;
		load_value(v, queue_results);
	endtask

	// Stop sending, let every expected result drain, then a few quiet cycles
	task automatic wait_idle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (sorted_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] a, input logic [31:0] d);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (a == ADDR_ELEMENT_COUNT) begin
			count_reg = d[6:0];
			loaded    = 0;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_read(input logic [2:0] a, input logic [31:0] want);
		logic [31:0] rd;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= a;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		rd = prdata;
		if (rd !== want) begin
			$display("%0t: read of 0x%0h expected 0x%08h got 0x%08h", $time, a, want, rd);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Count write with readback; upper data bits are random noise at times
	task automatic write_count(input int c);
		logic [31:0] d;
		d = c[6:0];
		if ($urandom_range(3) == 0)
			d = d | ($urandom << 7);
		reg_write(ADDR_ELEMENT_COUNT, d);
		check_read(ADDR_ELEMENT_COUNT, {25'd0, d[6:0]});
	endtask

	// Mostly small sets, now and then zero, full or above capacity
	function automatic int pick_count();
		int r;
		r = $urandom_range(99);
		if (r < 3)
			return 0;
		if (r < 6)
			return $urandom_range(127, 65);
		if (r < 9)
			return MAX_ELEMENTS;
		if (r < 70)
			return $urandom_range(8, 1);
		return $urandom_range(24, 9);
	endfunction

	function automatic logic [31:0] rand_value();
		int s;
		case ($urandom_range(3))
			0: begin
				s = int'($urandom_range(16)) - 8;
				return s;
			end
			1: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Random sets under one idle mix; some sets cut short by a count write
	task automatic run_phase(input int src_pct, input int sink_pct, input int first_count);
		int sent;
		int n;
		int k;
		int r;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		wait_idle();
		write_count(first_count);
		sent = 0;
		while (sent < ITEMS_PER_PHASE) begin
			n = set_size();
			r = $urandom_range(99);
			if (r < 10) begin
				k = $urandom_range(n - 1);
				repeat (k) send_beat(rand_value(), 1'b1);
				sent += k;
				wait_idle();
				write_count(pick_count());
			end else begin
				repeat (n) send_beat(rand_value(), 1'b1);
				sent += n;
				if (r < 40) begin
					wait_idle();
					write_count(pick_count());
				end else if (r < 50) begin
					wait_idle();
				end
			end
		end
	endtask

	// Sink side backpressure
	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= sink_stall_pct);

	// Output checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (sorted_q.size() == 0) begin
				$display("%0t: unexpected beat value 0x%08h last %0b", $time, m_tdata, m_tlast);
				errors++;
			end else begin
				want_beat = sorted_q.pop_front();
				if (m_tdata !== want_beat.value || m_tlast !== want_beat.last) begin
					$display("%0t: sorted beat expected 0x%08h last %0b, got 0x%08h last %0b",
						$time, want_beat.value, want_beat.last, m_tdata, m_tlast);
					errors++;
				end
			end
			beats_out++;
			if (m_tlast)
				sets_out++;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sorted_q.size());
			$display("FAIL");
			$finish;
		end
	end

	initial begin
		stim_row_t row;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		m_tready       = 1'b0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		errors         = 0;
		beats_in       = 0;
		beats_out      = 0;
		sets_out       = 0;
		cycles         = 0;
		count_reg      = 7'd64;
		loaded         = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table
		for (int r = 0; r < DIR_ROWS; r++) begin
			row = directed_rows[r];
			case (row.kind)
				ROW_WRITE: begin
					wait_idle();
					reg_write(row.addr, row.data);
				end
				ROW_READ: begin
					wait_idle();
					check_read(row.addr, row.want_data);
				end
				default: begin
					send_beat(row.data, !row.typed);
					if (row.typed) begin
						want_beat.value = row.want_data;
						want_beat.last  = row.want_last;
						sorted_q.push_back(want_beat);
					end
				end
			endcase
		end

		// Random sets under each handshake mix
		run_phase(0, 0, MAX_ELEMENTS);
		run_phase(67, 0, 127);
		run_phase(0, 67, 1);
		run_phase(33, 33, 0);

		wait_idle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d input beats and %0d sorted beats in %0d sets,", beats_in,
			beats_out, sets_out);
		$display("set sizes from one to full, zero and oversized counts, with and without stalls.");
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
